// ----- rtl/core/cfcc_pkg.sv -----
// Shared types and constants for the circle footprint collision checker.
`timescale 1ns / 1ps
`default_nettype none

package cfcc_pkg;

    // Width of the scaled cell-index numerators and of the quotient remainder.
    localparam int NW = 48;
    localparam int RW = 31;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_CELL_SIZE = 3'd2,
        CFG_CELLS_X   = 3'd3,
        CFG_CELLS_Y   = 3'd4,
        CFG_LENGTH    = 3'd5,
        CFG_WIDTH     = 3'd6,
        CFG_OVERHANG  = 3'd7
    } t_cfg_idx;

    // Sequencer states, one-hot.
    typedef enum logic [12:0] {
        ST_IDLE = 13'h0001,
        ST_PREP = 13'h0002,
        ST_SEL  = 13'h0004,
        ST_MUL  = 13'h0008,
        ST_NUM  = 13'h0010,
        ST_CHK  = 13'h0020,
        ST_DIV  = 13'h0040,
        ST_RD   = 13'h0080,
        ST_DS   = 13'h0100,
        ST_VAL  = 13'h0200,
        ST_SQ   = 13'h0400,
        ST_CMP  = 13'h0800,
        ST_DONE = 13'h1000
    } t_state;

    // Item actions.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    // Circle numbering: three coarse, four front, four rear.
    localparam logic [3:0] CIRC_MID        = 4'd1;
    localparam logic [3:0] CIRC_LAST_COARS = 4'd2;
    localparam logic [3:0] CIRC_FRONT0     = 4'd3;
    localparam logic [3:0] CIRC_FRONT_LAST = 4'd6;
    localparam logic [3:0] CIRC_REAR0      = 4'd7;
    localparam logic [3:0] CIRC_REAR_LAST  = 4'd10;

    // Margins, scaled by 96 for the coarse test and by 16 for the fine test.
    localparam logic [13:0] COARSE_MARGIN = 14'd13728;
    localparam logic [10:0] FINE_EXTRA    = 11'd1632;

    // Axle-to-centre pad before scaling by 24.
    localparam logic [23:0] REAR_PAD = 24'd205;

    // Circle offsets, in 1/24 of the base length unit.
    localparam logic [23:0] OFS_C0  = 24'd6144;
    localparam logic [23:0] OFS_C1  = 24'd1968;
    localparam logic [23:0] OFS_C2  = 24'd9840;
    localparam logic [23:0] OFS_F1  = 24'd6384;
    localparam logic [23:0] OFS_F2  = 24'd1464;
    localparam logic [23:0] OFS_R1  = 24'd2448;
    localparam logic [23:0] OFS_R2  = 24'd7872;
    localparam logic [23:0] OFS_BQ1 = 24'd8112;
    localparam logic [23:0] OFS_BQ2 = 24'd4920;

endpackage

`default_nettype wire

// ----- rtl/core/cfcc_in_if.sv -----
// Input channel of the collision checker: map writes and pose checks.
`timescale 1ns / 1ps
`default_nettype none

interface cfcc_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [7:0]         cell_row;
    logic [7:0]         cell_col;
    logic [11:0]        cell_distance;
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic signed [15:0] heading_cos;
    logic signed [15:0] heading_sin;

    modport source (
        output valid, action, cell_row, cell_col, cell_distance,
        output pose_x, pose_y, heading_cos, heading_sin,
        input  ready
    );
    modport sink (
        input  valid, action, cell_row, cell_col, cell_distance,
        input  pose_x, pose_y, heading_cos, heading_sin,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/cfcc_out_if.sv -----
// Result channel of the collision checker.
`timescale 1ns / 1ps
`default_nettype none

interface cfcc_out_if;
    logic       valid;
    logic       ready;
    logic       collision;
    logic [1:0] coarse_code;

    modport source (output valid, collision, coarse_code, input ready);
    modport sink   (input valid, collision, coarse_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cfcc_map.sv -----
// Distance map storage: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cfcc_map #(
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [11:0]              i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [11:0]                   o_rdata
);

    logic [11:0] r_mem [DEPTH];
    logic [11:0] r_rdata;

    // Write a cell when asked.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read every cycle; the data appears in the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/circle_footprint_collision_check.sv -----
// Circle footprint collision checker: distance map plus sequenced pose checks.
//
// Usage: items arrive on i_item. An item with action 0 writes one map cell
// (row, col, distance) and is absorbed in its accept cycle; it gives no
// result. An item with action 1 checks a pose and gives exactly one result
// on o_result: the coarse front/rear code and the collision flag.
// A check places up to eleven circle centres one after another. Each centre
// uses one shared 32x32 multiplier four times for the rotation, a restoring
// quotient of log2(MAP_SIDE) steps for both cell indexes, one map read, and
// two more multiplier passes for the distance test. The three coarse centres
// always run; the four front and the four rear fine centres each run only
// when the coarse code flags their end. Setup runs in ST_PREP before the
// first centre, and the result is handed off from ST_DONE.
// i_item.ready is high only while the sequencer is idle. A finished result
// sits in an output register; the next item is accepted while it waits, and
// a following check holds its result in the last state until o_result is
// taken. Reset (synchronous, active low) returns the sequencer to idle,
// drops the result valid and loads the register defaults; the map contents
// are not cleared, and a cell must be written before any check reads it.
// Configuration writes on i_cfg_* take effect at once and belong in idle time.
`timescale 1ns / 1ps
`default_nettype none

module circle_footprint_collision_check #(
    parameter int MAP_SIDE = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data,
    cfcc_in_if.sink          i_item,
    cfcc_out_if.source       o_result
);

    localparam int QW  = $clog2(MAP_SIDE);
    localparam int LW  = $clog2(MAP_SIDE + 1);
    localparam int MAW = $clog2(MAP_SIDE * MAP_SIDE);

    // Configuration registers.
    logic signed [23:0] r_origin_x, r_origin_y;
    logic [15:0]        r_cell_size, r_body_length, r_body_width, r_rear_overhang;
    logic [8:0]         r_cells_x, r_cells_y;

    // Control state.
    cfcc_pkg::t_state r_state;
    logic [3:0]       r_step;
    logic [3:0]       r_circ;
    logic [1:0]       r_h;
    logic [1:0]       r_code;
    logic             r_col;
    logic             r_out_valid, r_out_col;
    logic [1:0]       r_out_code;

    // Per-check and per-circle working registers.
    logic signed [23:0] r_px, r_py, r_rx, r_a, r_b;
    logic signed [15:0] r_c, r_s;
    logic signed [47:0] r_bx [2];
    logic signed [47:0] r_n [2];
    logic signed [47:0] r_ux, r_uy;
    logic [15:0]        r_sz;
    logic [17:0]        r_dq;
    logic [LW-1:0]      r_lim [2];
    logic [27:0]        r_limd [2];
    logic [31:0]        r_w2, r_l2;
    logic [44:0]        r_crhs;
    logic [36:0]        r_frhs;
    logic               r_ef;
    logic               r_ok [2];
    logic [cfcc_pkg::RW-1:0] r_rem [2];
    logic [cfcc_pkg::RW-1:0] r_dv;
    logic [QW-1:0]      r_q [2];
    logic [27:0]        r_ds;
    logic [30:0]        r_v;
    logic               r_small;
    logic [61:0]        r_sq;

    // Combinational signals.
    logic               acc;
    logic               wr_en;
    logic [20:0]        wr_lin, rd_lin;
    logic [MAW-1:0]     rd_addr;
    logic [11:0]        rd_data;
    logic [15:0]        sz_eff;
    logic signed [24:0] diff_x, diff_y;
    logic signed [47:0] ext_x, ext_y;
    logic [23:0]        l24, w24, rp24, q6, bq1, bq2;
    logic [23:0]        a_c0, a_c1, a_c2, a_f1, a_f2, a_r1, a_r2;
    logic [23:0]        sel_a, sel_b;
    logic               sel_e;
    logic signed [47:0] den;
    logic               chk_ok [2];
    logic [cfcc_pkg::RW-1:0] chk_rem [2];
    logic signed [47:0] nm1 [2];
    logic               ge [2];
    logic               is_fine;
    logic [36:0]        sc;
    logic [34:0]        sf;
    logic               hit;
    logic [1:0]         code_now;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;

    function automatic logic [LW-1:0] lim_of(input logic [8:0] cells);
        logic [LW-1:0] res;
        if (32'(cells) > MAP_SIDE) begin
            res = LW'(MAP_SIDE);
        end else begin
            res = LW'(cells);
        end
        return res;
    endfunction

    // Handshake.
    assign i_item.ready = (r_state == cfcc_pkg::ST_IDLE);
    assign acc          = i_item.valid && i_item.ready;

    assign o_result.valid       = r_out_valid;
    assign o_result.collision   = r_out_col;
    assign o_result.coarse_code = r_out_code;

    // Map write path: rows or columns beyond the map are dropped.
    assign wr_en  = acc && (i_item.action == cfcc_pkg::ACT_WRITE)
                    && (11'(i_item.cell_row) < 11'(MAP_SIDE))
                    && (11'(i_item.cell_col) < 11'(MAP_SIDE));
    assign wr_lin = 21'(i_item.cell_row) * 21'(MAP_SIDE) + 21'(i_item.cell_col);

    // Map read path: both indexes come out of the quotient unit.
    assign rd_lin  = 21'(r_q[0]) * 21'(MAP_SIDE) + 21'(r_q[1]);
    assign rd_addr = (r_ok[0] && r_ok[1]) ? rd_lin[MAW-1:0] : '0;

    cfcc_map #(
        .DEPTH (MAP_SIDE * MAP_SIDE)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_lin[MAW-1:0]),
        .i_wdata (i_item.cell_distance),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Setup terms for a check.
    assign sz_eff = (r_cell_size == '0) ? 16'd1 : r_cell_size;
    assign diff_x = {r_origin_x[23], r_origin_x} - {r_px[23], r_px};
    assign diff_y = {r_origin_y[23], r_origin_y} - {r_py[23], r_py};
    assign ext_x  = {{23{diff_x[24]}}, diff_x};
    assign ext_y  = {{23{diff_y[24]}}, diff_y};
    assign l24    = {8'b0, r_body_length};
    assign w24    = {8'b0, r_body_width};
    assign rp24   = {8'b0, r_rear_overhang} + cfcc_pkg::REAR_PAD;
    assign q6     = (w24 << 2) + (w24 << 1);
    assign bq1    = q6 - cfcc_pkg::OFS_BQ1;
    assign bq2    = q6 - cfcc_pkg::OFS_BQ2;
    assign sc     = 37'({r_w2, 3'b0}) + 37'(r_w2) + 37'(r_l2);
    assign sf     = 35'({r_w2, 2'b0}) + 35'(r_l2);

    // Circle centre offsets along and across the axis.
    assign a_c0 = r_rx + (l24 << 3) - cfcc_pkg::OFS_C0;
    assign a_c1 = r_rx + cfcc_pkg::OFS_C1;
    assign a_c2 = r_rx - (l24 << 3) + cfcc_pkg::OFS_C2;
    assign a_f1 = r_rx + (l24 << 3) + l24 - cfcc_pkg::OFS_F1;
    assign a_f2 = r_rx + (l24 << 1) + l24 - cfcc_pkg::OFS_F2;
    assign a_r1 = r_rx - (l24 << 1) - l24 + cfcc_pkg::OFS_R1;
    assign a_r2 = r_rx - (l24 << 3) - l24 + cfcc_pkg::OFS_R2;

    always_comb begin
        sel_a = a_c0;
        sel_b = '0;
        sel_e = 1'b0;
        case (r_circ)
            4'd0:  begin sel_a = a_c0; end
            4'd1:  begin sel_a = a_c1; end
            4'd2:  begin sel_a = a_c2; end
            4'd3:  begin sel_a = a_f1; sel_b = bq1;      sel_e = 1'b1; end
            4'd4:  begin sel_a = a_f2; sel_b = bq2;                    end
            4'd5:  begin sel_a = a_f1; sel_b = '0 - bq1; sel_e = 1'b1; end
            4'd6:  begin sel_a = a_f2; sel_b = '0 - bq2;               end
            4'd7:  begin sel_a = a_r1; sel_b = bq2;                    end
            4'd8:  begin sel_a = a_r2; sel_b = bq1;      sel_e = 1'b1; end
            4'd9:  begin sel_a = a_r1; sel_b = '0 - bq2;               end
            4'd10: begin sel_a = a_r2; sel_b = '0 - bq1; sel_e = 1'b1; end
            default: begin sel_a = a_c0; end
        endcase
    end

    // Range checks on the scaled numerators, one lane per axis.
    assign den = {30'b0, r_dq} <<< 17;
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            nm1[i]     = r_n[i] - 48'sd1;
            chk_rem[i] = (r_n[i] > 48'sd0) ? nm1[i][47:17] : '0;
            chk_ok[i]  = ((r_n[i] + den) > 48'sd0)
                         && ((r_n[i] <= 48'sd0) || (nm1[i][47:17] < 31'(r_limd[i])))
                         && (r_lim[i] != '0);
            ge[i]      = (r_rem[i] >= r_dv);
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            cfcc_pkg::ST_PREP: begin
                case (r_step[1:0])
                    2'd0:    begin mul_a = {16'b0, r_body_width};  mul_b = {16'b0, r_body_width};  end
                    2'd1:    begin mul_a = {16'b0, r_body_length}; mul_b = {16'b0, r_body_length}; end
                    2'd2:    begin mul_a = 32'(r_lim[0]); mul_b = {14'b0, r_dq}; end
                    default: begin mul_a = 32'(r_lim[1]); mul_b = {14'b0, r_dq}; end
                endcase
            end
            cfcc_pkg::ST_MUL: begin
                case (r_step[1:0])
                    2'd0:    begin mul_a = {{8{r_a[23]}}, r_a}; mul_b = {{16{r_c[15]}}, r_c}; end
                    2'd1:    begin mul_a = {{8{r_b[23]}}, r_b}; mul_b = {{16{r_s[15]}}, r_s}; end
                    2'd2:    begin mul_a = {{8{r_a[23]}}, r_a}; mul_b = {{16{r_s[15]}}, r_s}; end
                    default: begin mul_a = {{8{r_b[23]}}, r_b}; mul_b = {{16{r_c[15]}}, r_c}; end
                endcase
            end
            cfcc_pkg::ST_DS: begin
                mul_a = {20'b0, rd_data};
                mul_b = {16'b0, r_sz};
            end
            cfcc_pkg::ST_SQ: begin
                mul_a = {1'b0, r_v};
                mul_b = {1'b0, r_v};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Hit decision for the current circle and the coarse code it completes.
    assign is_fine  = (r_circ >= cfcc_pkg::CIRC_FRONT0);
    assign hit      = !(r_ok[0] && r_ok[1]) || r_small
                      || (is_fine ? (r_sq <= 62'(r_frhs)) : (r_sq <= 62'(r_crhs)));
    assign code_now = r_h[1] ? 2'b11 : {hit, r_h[0]};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_cell_size     <= 16'd102;
            r_cells_x       <= 9'd256;
            r_cells_y       <= 9'd256;
            r_body_length   <= 16'd5427;
            r_body_width    <= 16'd2355;
            r_rear_overhang <= 16'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfcc_pkg::CFG_ORIGIN_X:  r_origin_x      <= i_cfg_data;
                cfcc_pkg::CFG_ORIGIN_Y:  r_origin_y      <= i_cfg_data;
                cfcc_pkg::CFG_CELL_SIZE: r_cell_size     <= i_cfg_data[15:0];
                cfcc_pkg::CFG_CELLS_X:   r_cells_x       <= i_cfg_data[8:0];
                cfcc_pkg::CFG_CELLS_Y:   r_cells_y       <= i_cfg_data[8:0];
                cfcc_pkg::CFG_LENGTH:    r_body_length   <= i_cfg_data[15:0];
                cfcc_pkg::CFG_WIDTH:     r_body_width    <= i_cfg_data[15:0];
                cfcc_pkg::CFG_OVERHANG:  r_rear_overhang <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfcc_pkg::ST_IDLE;
            r_step      <= '0;
            r_circ      <= '0;
            r_h         <= '0;
            r_code      <= '0;
            r_col       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_col   <= 1'b0;
            r_out_code  <= '0;
        end else begin
            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                cfcc_pkg::ST_IDLE: begin
                    if (acc && (i_item.action == cfcc_pkg::ACT_CHECK)) begin
                        r_state <= cfcc_pkg::ST_PREP;
                        r_step  <= '0;
                        r_circ  <= '0;
                        r_code  <= '0;
                        r_h     <= '0;
                        r_col   <= 1'b0;
                    end
                end
                cfcc_pkg::ST_PREP: begin
                    r_step <= r_step + 4'd1;
                    if (r_step[1:0] == 2'd3) begin
                        r_state <= cfcc_pkg::ST_SEL;
                    end
                end
                cfcc_pkg::ST_SEL: begin
                    r_state <= cfcc_pkg::ST_MUL;
                    r_step  <= '0;
                end
                cfcc_pkg::ST_MUL: begin
                    r_step <= r_step + 4'd1;
                    if (r_step[1:0] == 2'd3) begin
                        r_state <= cfcc_pkg::ST_NUM;
                    end
                end
                cfcc_pkg::ST_NUM: begin
                    r_state <= cfcc_pkg::ST_CHK;
                end
                cfcc_pkg::ST_CHK: begin
                    r_state <= cfcc_pkg::ST_DIV;
                    r_step  <= '0;
                end
                cfcc_pkg::ST_DIV: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'(QW - 1)) begin
                        r_state <= cfcc_pkg::ST_RD;
                    end
                end
                cfcc_pkg::ST_RD:  r_state <= cfcc_pkg::ST_DS;
                cfcc_pkg::ST_DS:  r_state <= cfcc_pkg::ST_VAL;
                cfcc_pkg::ST_VAL: r_state <= cfcc_pkg::ST_SQ;
                cfcc_pkg::ST_SQ:  r_state <= cfcc_pkg::ST_CMP;
                cfcc_pkg::ST_CMP: begin
                    if (is_fine) begin
                        r_col <= r_col || hit;
                    end
                    if (r_circ < cfcc_pkg::CIRC_LAST_COARS) begin
                        r_h[r_circ[0]] <= hit;
                        r_circ         <= r_circ + 4'd1;
                        r_state        <= cfcc_pkg::ST_SEL;
                    end else if (r_circ == cfcc_pkg::CIRC_LAST_COARS) begin
                        r_code <= code_now;
                        if (code_now[0]) begin
                            r_circ  <= cfcc_pkg::CIRC_FRONT0;
                            r_state <= cfcc_pkg::ST_SEL;
                        end else if (code_now[1]) begin
                            r_circ  <= cfcc_pkg::CIRC_REAR0;
                            r_state <= cfcc_pkg::ST_SEL;
                        end else begin
                            r_state <= cfcc_pkg::ST_DONE;
                        end
                    end else if (r_circ == cfcc_pkg::CIRC_FRONT_LAST) begin
                        if (r_code[1]) begin
                            r_circ  <= cfcc_pkg::CIRC_REAR0;
                            r_state <= cfcc_pkg::ST_SEL;
                        end else begin
                            r_state <= cfcc_pkg::ST_DONE;
                        end
                    end else if (r_circ == cfcc_pkg::CIRC_REAR_LAST) begin
                        r_state <= cfcc_pkg::ST_DONE;
                    end else begin
                        r_circ  <= r_circ + 4'd1;
                        r_state <= cfcc_pkg::ST_SEL;
                    end
                end
                cfcc_pkg::ST_DONE: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_col   <= r_col;
                        r_out_code  <= r_code;
                        r_state     <= cfcc_pkg::ST_IDLE;
                    end
                end
                default: r_state <= cfcc_pkg::ST_IDLE;
            endcase
        end
    end

    // Datapath registers, loaded step by step under the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cfcc_pkg::ST_IDLE: begin
                if (acc) begin
                    r_px <= i_item.pose_x;
                    r_py <= i_item.pose_y;
                    r_c  <= i_item.heading_cos;
                    r_s  <= i_item.heading_sin;
                end
            end
            cfcc_pkg::ST_PREP: begin
                case (r_step[1:0])
                    2'd0: begin
                        r_w2     <= mul_p[31:0];
                        r_rx     <= (l24 << 3) + (l24 << 2) - ((rp24 << 4) + (rp24 << 3));
                        r_bx[0]  <= (ext_x <<< 17) + (ext_x <<< 18);
                        r_bx[1]  <= (ext_y <<< 17) + (ext_y <<< 18);
                        r_sz     <= sz_eff;
                        r_dq     <= {2'b0, sz_eff} + {1'b0, sz_eff, 1'b0};
                        r_lim[0] <= lim_of(r_cells_x);
                        r_lim[1] <= lim_of(r_cells_y);
                    end
                    2'd1: begin
                        r_l2 <= mul_p[31:0];
                    end
                    2'd2: begin
                        r_limd[0] <= mul_p[27:0];
                        r_crhs    <= {sc, 8'b0};
                        r_frhs    <= {sf, 2'b0};
                    end
                    default: begin
                        r_limd[1] <= mul_p[27:0];
                    end
                endcase
            end
            cfcc_pkg::ST_SEL: begin
                r_a  <= sel_a;
                r_b  <= sel_b;
                r_ef <= sel_e;
            end
            cfcc_pkg::ST_MUL: begin
                case (r_step[1:0])
                    2'd0:    r_ux <= mul_p[47:0];
                    2'd1:    r_ux <= r_ux - mul_p[47:0];
                    2'd2:    r_uy <= mul_p[47:0];
                    default: r_uy <= r_uy + mul_p[47:0];
                endcase
            end
            cfcc_pkg::ST_NUM: begin
                r_n[0] <= r_bx[0] - r_ux;
                r_n[1] <= r_bx[1] - r_uy;
            end
            cfcc_pkg::ST_CHK: begin
                for (int i = 0; i < 2; i++) begin
                    r_ok[i]  <= chk_ok[i];
                    r_rem[i] <= chk_rem[i];
                    r_q[i]   <= '0;
                end
                r_dv <= cfcc_pkg::RW'(r_dq) << (QW - 1);
            end
            cfcc_pkg::ST_DIV: begin
                for (int i = 0; i < 2; i++) begin
                    if (ge[i]) begin
                        r_rem[i] <= r_rem[i] - r_dv;
                    end
                    r_q[i] <= {r_q[i][QW-2:0], ge[i]};
                end
                r_dv <= r_dv >> 1;
            end
            cfcc_pkg::ST_DS: begin
                r_ds <= mul_p[27:0];
            end
            cfcc_pkg::ST_VAL: begin
                if (is_fine) begin
                    r_v     <= r_ef ? (31'(r_ds) - 31'(cfcc_pkg::FINE_EXTRA)) : 31'(r_ds);
                    r_small <= r_ef ? (r_ds <= 28'(cfcc_pkg::FINE_EXTRA)) : (r_ds == '0);
                end else begin
                    r_v     <= {1'b0, r_ds, 2'b0} + {2'b0, r_ds, 1'b0}
                               + 31'(cfcc_pkg::COARSE_MARGIN);
                    r_small <= 1'b0;
                end
            end
            cfcc_pkg::ST_SQ: begin
                r_sq <= mul_p[61:0];
            end
            default: ;
        endcase
    end

    // A check item starts the sequencer; a write item leaves it idle.
    a_check_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_item.action == cfcc_pkg::ACT_CHECK) |=> (r_state == cfcc_pkg::ST_PREP))
        else $error("check item did not start the sequencer");

    a_write_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_item.action == cfcc_pkg::ACT_WRITE) |=> (r_state == cfcc_pkg::ST_IDLE))
        else $error("write item left the idle state");

    // Fine circles are only visited on an end that the coarse code flags.
    a_front_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfcc_pkg::ST_SEL && r_circ >= cfcc_pkg::CIRC_FRONT0
         && r_circ <= cfcc_pkg::CIRC_FRONT_LAST) |-> r_code[0])
        else $error("front circle visited without front flag");

    a_rear_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfcc_pkg::ST_SEL && r_circ >= cfcc_pkg::CIRC_REAR0) |-> r_code[1])
        else $error("rear circle visited without rear flag");

    // A result only appears from the hand-off state.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == cfcc_pkg::ST_DONE))
        else $error("result loaded outside the hand-off state");

    // The quotient loop never runs past its bit count.
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfcc_pkg::ST_DIV) |-> (r_step < 4'(QW)))
        else $error("quotient loop overran");

endmodule

`default_nettype wire

// ----- tb/sv/tb_cfcc_checker.sv -----
// Checker for the collision checker: tracks config and map, predicts and compares results.
`timescale 1ns / 1ps
`default_nettype none

module tb_cfcc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data,
    cfcc_in_if               item_ch,
    cfcc_out_if              res_ch,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checks,
    output int               o_collisions,
    output int               o_flagged
);

    localparam longint POS_SCALE = 24 * 16384;
    localparam longint SIDE = 256;

    typedef struct packed {
        logic       collision;
        logic [1:0] coarse_code;
    } t_verdict;

    // Local copy of the configuration registers and of the distance map.
    logic signed [23:0] org_x, org_y;
    logic [15:0]        cell_sz, body_len, body_wid, overhang;
    logic [8:0]         lim_x, lim_y;
    logic [11:0]        dist_map [0:65535];
    t_verdict           verdicts_due [$];
    int                 fails, checks, collisions, flagged;

    assign o_fail_count = fails;
    assign o_pending    = verdicts_due.size();
    assign o_checks     = checks;
    assign o_collisions = collisions;
    assign o_flagged    = flagged;

    function automatic longint ceil_quot(input longint n, input longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n > 0) q++;
        return q;
    endfunction

    // Finds the map cell under a centre; returns 0 when it lies off the map.
    function automatic bit cell_lookup(input longint a, input longint b, input longint px,
                                       input longint py, input longint c, input longint s,
                                       output longint cell_dist);
        longint sz, den, nx, ny, xi, yi, lx, ly;
        sz = (cell_sz == 0) ? 1 : longint'(cell_sz);
        den = POS_SCALE * sz;
        nx = (longint'(org_x) - px) * POS_SCALE - (a * c - b * s);
        ny = (longint'(org_y) - py) * POS_SCALE - (a * s + b * c);
        xi = ceil_quot(nx, den);
        yi = ceil_quot(ny, den);
        lx = (lim_x < SIDE) ? longint'(lim_x) : SIDE;
        ly = (lim_y < SIDE) ? longint'(lim_y) : SIDE;
        cell_dist = 0;
        if (xi == 0) xi = 1;
        if (yi == 0) yi = 1;
        if (xi < 1 || xi > lx || yi < 1 || yi > ly) return 1'b0;
        cell_dist = dist_map[(xi - 1) * SIDE + (yi - 1)];
        return 1'b1;
    endfunction

    function automatic bit coarse_hit(input longint a, input longint px, input longint py,
                                      input longint c, input longint s);
        longint d, sz, lhs, w, l;
        if (!cell_lookup(a, 0, px, py, c, s, d)) return 1'b1;
        sz = (cell_sz == 0) ? 1 : longint'(cell_sz);
        w = body_wid;
        l = body_len;
        lhs = 6 * d * sz + 96 * 143;
        return lhs * lhs <= 256 * (9 * w * w + l * l);
    endfunction

    function automatic bit fine_hit(input longint a, input longint b, input longint extra,
                                    input longint px, input longint py, input longint c,
                                    input longint s);
        longint d, sz, ds, t, w, l;
        if (!cell_lookup(a, b, px, py, c, s, d)) return 1'b1;
        sz = (cell_sz == 0) ? 1 : longint'(cell_sz);
        w = body_wid;
        l = body_len;
        ds = d * sz;
        if (ds <= 16 * extra) return 1'b1;
        t = ds - 16 * extra;
        return t * t <= 4 * (4 * w * w + l * l);
    endfunction

    // Works out the coarse code and the collision flag of one pose.
    // Offsets are kept in units of 1/24 of the base length unit.
    function automatic t_verdict judge_pose(input logic signed [23:0] pxi,
                                            input logic signed [23:0] pyi,
                                            input logic signed [15:0] ci,
                                            input logic signed [15:0] si);
        longint px, py, c, s, l, w, rx, off, q, a1, a2;
        bit h1, h2, h3, hit;
        logic [1:0] code;
        t_verdict v;
        px = pxi;
        py = pyi;
        c = ci;
        s = si;
        l = body_len;
        w = body_wid;
        rx = 12 * l - 24 * (longint'(overhang) + 205);
        h1 = coarse_hit(rx + 8 * l - 24 * 256, px, py, c, s);
        h2 = coarse_hit(rx + 24 * 82, px, py, c, s);
        h3 = coarse_hit(rx - 8 * l + 24 * 410, px, py, c, s);
        code = h2 ? 2'd3 : {h3, h1};
        off = 3 * l;
        q = 6 * w;
        hit = 0;
        if (code[0]) begin
            a1 = rx + 3 * off - 24 * 266;
            a2 = rx + off - 24 * 61;
            hit = fine_hit(a1, q - 24 * 338, 102, px, py, c, s)
               || fine_hit(a2, q - 24 * 205, 0, px, py, c, s)
               || fine_hit(a1, -q + 24 * 338, 102, px, py, c, s)
               || fine_hit(a2, -q + 24 * 205, 0, px, py, c, s);
        end
        if (code[1] && !hit) begin
            a1 = rx - off + 24 * 102;
            a2 = rx - 3 * off + 24 * 328;
            hit = fine_hit(a1, q - 24 * 205, 0, px, py, c, s)
               || fine_hit(a2, q - 24 * 338, 102, px, py, c, s)
               || fine_hit(a1, -q + 24 * 205, 0, px, py, c, s)
               || fine_hit(a2, -q + 24 * 338, 102, px, py, c, s);
        end
        v.collision = hit;
        v.coarse_code = code;
        return v;
    endfunction

    initial begin
        fails = 0;
        checks = 0;
        collisions = 0;
        flagged = 0;
    end

    // Configuration, result comparison, then the accepted item, all at the clock edge.
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            org_x    <= '0;
            org_y    <= '0;
            cell_sz  <= 16'd102;
            lim_x    <= 9'd256;
            lim_y    <= 9'd256;
            body_len <= 16'd5427;
            body_wid <= 16'd2355;
            overhang <= 16'd1024;
        end else if (i_cfg_we) begin
            case (cfcc_pkg::t_cfg_idx'(i_cfg_idx))
                cfcc_pkg::CFG_ORIGIN_X:  org_x    <= i_cfg_data;
                cfcc_pkg::CFG_ORIGIN_Y:  org_y    <= i_cfg_data;
                cfcc_pkg::CFG_CELL_SIZE: cell_sz  <= i_cfg_data[15:0];
                cfcc_pkg::CFG_CELLS_X:   lim_x    <= i_cfg_data[8:0];
                cfcc_pkg::CFG_CELLS_Y:   lim_y    <= i_cfg_data[8:0];
                cfcc_pkg::CFG_LENGTH:    body_len <= i_cfg_data[15:0];
                cfcc_pkg::CFG_WIDTH:     body_wid <= i_cfg_data[15:0];
                cfcc_pkg::CFG_OVERHANG:  overhang <= i_cfg_data[15:0];
                default: ;
            endcase
        end

        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (verdicts_due.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("ERROR: result with nothing expected: collision %0b code %0d",
                             res_ch.collision, res_ch.coarse_code);
            end else begin
                want = verdicts_due.pop_front();
                if (want.collision !== res_ch.collision
                        || want.coarse_code !== res_ch.coarse_code) begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR: expected collision %0b code %0d, got %0b code %0d",
                                 want.collision, want.coarse_code,
                                 res_ch.collision, res_ch.coarse_code);
                end
            end
        end

        if (i_rst_n && item_ch.valid && item_ch.ready) begin
            if (item_ch.action == cfcc_pkg::ACT_WRITE) begin
                dist_map[{item_ch.cell_row, item_ch.cell_col}] = item_ch.cell_distance;
            end else begin
                want = judge_pose(item_ch.pose_x, item_ch.pose_y,
                                  item_ch.heading_cos, item_ch.heading_sin);
                verdicts_due.push_back(want);
                checks++;
                if (want.collision) collisions++;
                if (want.coarse_code != 2'd0) flagged++;
            end
        end
    end
endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Top of the collision checker testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 115;
    localparam int FILL_SIDE   = 24;

    typedef struct {
        logic               action;
        logic [7:0]         cell_row;
        logic [7:0]         cell_col;
        logic [11:0]        cell_distance;
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic signed [15:0] heading_cos;
        logic signed [15:0] heading_sin;
    } t_pose_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;
    int          fail_count, pending, checks, collisions, flagged;
    int          idle_cycles;
    bit          hold_wanted, hold_done;

    // Settings of the current phase, used to aim poses at the map.
    longint ph_org_x, ph_org_y, ph_size, ph_cells;

    cfcc_in_if  item_ch ();
    cfcc_out_if res_ch ();

    circle_footprint_collision_check uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_result   (res_ch)
    );

    tb_cfcc_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .item_ch      (item_ch),
        .res_ch       (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checks     (checks),
        .o_collisions (collisions),
        .o_flagged    (flagged)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("circle_footprint_collision_check test failed");
            $finish;
        end
    end

    // Result side: bursts of steady readiness and random stalls, plus one long hold-off.
    initial begin
        int mode;
        res_ch.ready <= 1'b0;
        hold_done = 0;
        forever begin
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 64; k++) begin
                @(posedge i_clk);
                if (hold_wanted && !hold_done) begin
                    res_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_done = 1;
                    res_ch.ready <= 1'b1;
                end else if (mode == 0) begin
                    res_ch.ready <= 1'b1;
                end else if ($urandom_range(0, 99) < 3) begin
                    res_ch.ready <= 1'b0;
                    repeat ($urandom_range(10, 80)) @(posedge i_clk);
                    res_ch.ready <= 1'b1;
                end else begin
                    res_ch.ready <= ($urandom_range(0, 99) < 65);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [23:0] clamp24(input longint v);
        if (v > 8388607) return 24'sd8388607;
        if (v < -8388608) return -24'sd8388608;
        return v[23:0];
    endfunction

    // Offers one item and waits until the block takes it.
    task automatic push_item(input t_pose_item it, input int gap);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.action        <= it.action;
        item_ch.cell_row      <= it.cell_row;
        item_ch.cell_col      <= it.cell_col;
        item_ch.cell_distance <= it.cell_distance;
        item_ch.pose_x        <= it.pose_x;
        item_ch.pose_y        <= it.pose_y;
        item_ch.heading_cos   <= it.heading_cos;
        item_ch.heading_sin   <= it.heading_sin;
        item_ch.valid         <= 1'b1;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    function automatic t_pose_item map_write(input logic [7:0] row, input logic [7:0] col,
                                             input logic [11:0] cell_dist);
        t_pose_item it;
        it.action = cfcc_pkg::ACT_WRITE;
        it.cell_row = row;
        it.cell_col = col;
        it.cell_distance = cell_dist;
        it.pose_x = 24'($urandom());
        it.pose_y = 24'($urandom());
        it.heading_cos = 16'($urandom());
        it.heading_sin = 16'($urandom());
        return it;
    endfunction

    function automatic t_pose_item pose_check(input longint px, input longint py,
                                              input int c, input int s);
        t_pose_item it;
        it = map_write(8'($urandom()), 8'($urandom()), 12'($urandom()));
        it.action = cfcc_pkg::ACT_CHECK;
        it.pose_x = clamp24(px);
        it.pose_y = clamp24(py);
        it.heading_cos = c[15:0];
        it.heading_sin = s[15:0];
        return it;
    endfunction

    // Free distances lean toward the range where the hit tests change outcome.
    function automatic logic [11:0] rand_distance();
        if ($urandom_range(0, 99) < 70) return 12'($urandom_range(0, 600));
        return 12'($urandom_range(0, 4095));
    endfunction

    // A random check: mostly a unit heading with the pose aimed inside the map.
    function automatic t_pose_item rand_check();
        longint span, px, py;
        real th;
        int c, s;
        span = ph_cells * ph_size + 2 * ph_size;
        if ($urandom_range(0, 99) < 10) begin
            px = $signed(24'($urandom()));
            py = $signed(24'($urandom()));
        end else begin
            px = ph_org_x - longint'($urandom_range(0, 32'(span)));
            py = ph_org_y - longint'($urandom_range(0, 32'(span)));
        end
        if ($urandom_range(0, 99) < 10) begin
            c = $urandom();
            s = $urandom();
        end else begin
            th = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
            c = $rtoi($cos(th) * 16384.0);
            s = $rtoi($sin(th) * 16384.0);
        end
        return pose_check(px, py, c, s);
    endfunction

    // Loads all eight registers; the write enable stays high across the batch.
    task automatic load_settings(input longint ox, input longint oy, input int sz,
                                 input int cx, input int cy, input int len, input int wid,
                                 input int ovh);
        logic [23:0] vals [8];
        vals[cfcc_pkg::CFG_ORIGIN_X]  = ox[23:0];
        vals[cfcc_pkg::CFG_ORIGIN_Y]  = oy[23:0];
        vals[cfcc_pkg::CFG_CELL_SIZE] = 24'(sz);
        vals[cfcc_pkg::CFG_CELLS_X]   = 24'(cx);
        vals[cfcc_pkg::CFG_CELLS_Y]   = 24'(cy);
        vals[cfcc_pkg::CFG_LENGTH]    = 24'(len);
        vals[cfcc_pkg::CFG_WIDTH]     = 24'(wid);
        vals[cfcc_pkg::CFG_OVERHANG]  = 24'(ovh);
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        ph_org_x = $signed(ox[23:0]);
        ph_org_y = $signed(oy[23:0]);
        ph_size  = (sz == 0) ? 1 : sz;
        ph_cells = (cx > cy) ? cx : cy;
        if (ph_cells > 256) ph_cells = 256;
        if (ph_cells == 0) ph_cells = 8;
    endtask

    // Waits until every check has its result and the block is idle.
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        // Reachable cells stay inside the filled corner, except in one phase that reads
        // only the first column and has a first count above the map side.
        longint ph_ox [NUM_PHASES] = '{0, 8388607, -8388608, 12345, 0, -3000, 40000, 0};
        longint ph_oy [NUM_PHASES] = '{0, -8388608, 8388607, -4321, 0, 2000, -40000, 500};
        int ph_sz  [NUM_PHASES] = '{102, 102, 0, 65535, 1, 50, 400, 20};
        int ph_cx  [NUM_PHASES] = '{24, 300, 16, 24, 1, 0, 20, 24};
        int ph_cy  [NUM_PHASES] = '{24, 1, 16, 24, 1, 40, 24, 24};
        int ph_len [NUM_PHASES] = '{5427, 5427, 1, 65535, 3000, 4000, 8000, 800};
        int ph_wid [NUM_PHASES] = '{2355, 2355, 1, 65535, 1500, 2000, 3000, 400};
        int ph_ovh [NUM_PHASES] = '{1024, 0, 65535, 65535, 500, 800, 1500, 100};

        // Every input starts at a known value while reset is held.
        hold_wanted = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        item_ch.valid <= 1'b0;
        item_ch.action <= cfcc_pkg::ACT_WRITE;
        item_ch.cell_row <= '0;
        item_ch.cell_col <= '0;
        item_ch.cell_distance <= '0;
        item_ch.pose_x <= '0;
        item_ch.pose_y <= '0;
        item_ch.heading_cos <= '0;
        item_ch.heading_sin <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the corner of the map and the whole first column, which covers
        // every cell that the phase settings below let a check reach.
        load_settings(ph_ox[0], ph_oy[0], ph_sz[0], ph_cx[0], ph_cy[0],
                      ph_len[0], ph_wid[0], ph_ovh[0]);
        for (int r = 0; r < FILL_SIDE; r++)
            for (int k = 0; k < FILL_SIDE; k++)
                push_item(map_write(r[7:0], k[7:0], rand_distance()), 0);
        for (int r = FILL_SIDE; r < 256; r++)
            push_item(map_write(r[7:0], 8'd0, rand_distance()), 0);

        // Directed: field extremes, cardinal and diagonal headings, off-map poses,
        // out-of-range trig and centres that land on index zero.
        push_item(map_write(8'd255, 8'd255, 12'd4095), pick_gap());
        push_item(map_write(8'd0, 8'd0, 12'd0), pick_gap());
        push_item(map_write(8'd12, 8'd11, 12'd4095), pick_gap());
        push_item(pose_check(-1200, -1200, 16384, 0), pick_gap());
        push_item(pose_check(-1200, -1200, 0, 16384), pick_gap());
        push_item(pose_check(-1200, -1200, -16384, 0), pick_gap());
        push_item(pose_check(-1200, -1200, 0, -16384), pick_gap());
        push_item(pose_check(-1200, -1200, 11585, 11585), pick_gap());
        push_item(pose_check(-1200, -1200, 16384, 16384), pick_gap());
        push_item(pose_check(-1200, -1200, -16384, -16384), pick_gap());
        push_item(pose_check(-1200, -1200, -32768, 32767), pick_gap());
        push_item(pose_check(-8388608, -8388608, 16384, 0), pick_gap());
        push_item(pose_check(8388607, 8388607, 16384, 0), pick_gap());
        push_item(pose_check(0, 0, 0, 0), pick_gap());
        push_item(pose_check(-20, -20, 0, 0), pick_gap());
        push_item(pose_check(-2448, -2448, 0, 0), pick_gap());
        push_item(pose_check(-2400, -100, -16384, 0), pick_gap());
        push_item(pose_check(-500, -2000, 0, 0), pick_gap());

        // Random phases, one per register setting, with a long receiver hold-off early on.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            load_settings(ph_ox[p], ph_oy[p], ph_sz[p], ph_cx[p], ph_cy[p],
                          ph_len[p], ph_wid[p], ph_ovh[p]);
            if (p == 0) hold_wanted = 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 20)
                    push_item(map_write(8'($urandom()), 8'($urandom()), rand_distance()),
                              pick_gap());
                else
                    push_item(rand_check(), pick_gap());
            end
        end

        drain();
        repeat (300) @(posedge i_clk);
        $display("Ran %0d pose checks over %0d register settings after a map corner load.",
                 checks, NUM_PHASES);
        $display("Checks with an end flagged: %0d, with a collision: %0d.",
                 flagged, collisions);
        if (fail_count == 0)
            $display("circle_footprint_collision_check test passed");
        else
            $display("circle_footprint_collision_check test failed");
        $finish;
    end
endmodule

`default_nettype wire
